// File: hw/rtl/sorted_summary_quantile_defines.svh
// Assertion macros for the sorted summary quantile block.
`ifndef SORTED_SUMMARY_QUANTILE_DEFINES_SVH
`define SORTED_SUMMARY_QUANTILE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ssq_pkg.sv
package ssq_pkg;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned PCT_W     = 7;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         instance_req;
    logic signed [31:0] sample_value;
    logic [PCT_W-1:0]   quantile_pct;
  } ssq_in_t;

  typedef struct packed {
    logic signed [31:0] quantile_value;
    logic [8:0]         count_after;
    logic signed [31:0] sum_after;
    logic               dropped;
  } ssq_out_t;

  typedef struct packed {
    logic latch;
    logic meta_rd;
    logic meta_load;
    logic mark_drop;
    logic obs_init;
    logic scan_rd;
    logic shift_wr;
    logic ins_wr;
    logic clear;
    logic q_mul;
    logic q_div;
    logic q_idx;
    logic q_rd;
    logic q_cap;
    logic finish;
  } ssq_cmd_t;

  typedef struct packed {
    logic       bad_inst;
    logic [1:0] command;
    logic       empty;
    logic       full;
    logic       j_zero;
    logic       le;
  } ssq_stat_t;

endpackage

// File: hw/rtl/ssq_ram.sv
module ssq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/ssq_dp.sv
module ssq_dp import ssq_pkg::*; #(
  parameter int unsigned CAPACITY      = 256,
  parameter int unsigned NUM_INSTANCES = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ssq_in_t   in_item,
  input  ssq_cmd_t  cmd,
  output ssq_stat_t stat,
  output logic      out_valid,
  output ssq_out_t  out_item
);

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned IW  = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
  localparam int unsigned SD  = NUM_INSTANCES * CAPACITY;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned PW  = CW + PCT_W;
  localparam int unsigned QS  = PW + 6;
  localparam int unsigned MW  = PW + QS;
  localparam logic [QS-1:0] QM = QS'((64'd1 << QS) / PCT_SCALE);

  ssq_in_t            item_r;
  logic               bad_r;
  logic [SAW-1:0]     base_r;
  logic [CW-1:0]      cnt_r;
  logic signed [31:0] sum_r;
  logic [CW-1:0]      j_r;
  logic [PW-1:0]      prod_r;
  logic [MW-1:0]      mul_r;
  logic [CW-1:0]      idx_r;
  logic signed [31:0] qv_r;
  logic               drop_r;
  logic [NUM_INSTANCES-1:0] valid_r;
  logic               out_valid_r;
  ssq_out_t           out_r;

  logic [IW-1:0]      inst_a;
  logic [CW+31:0]     meta_rd_data;
  logic [31:0]        store_rd_data;
  logic [SAW-1:0]     store_wr_addr;
  logic [SAW-1:0]     store_rd_addr;
  logic [31:0]        store_wr_data;
  logic [PW-1:0]      q0;
  logic [PW-1:0]      rem;
  logic [PW-1:0]      qc;
  logic [CW-1:0]      idx_nxt;

  assign inst_a = IW'(item_r.instance_req);

  assign store_wr_addr = base_r + SAW'(j_r);
  assign store_wr_data = cmd.ins_wr ? 32'(item_r.sample_value) : store_rd_data;
  assign store_rd_addr = cmd.q_rd ? (base_r + SAW'(idx_r)) : (base_r + SAW'(j_r) - SAW'(1));

  // idx = floor(cnt*pct/100) via reciprocal, one-step correction, clamp to cnt-1
  assign q0      = PW'(mul_r >> QS);
  assign rem     = prod_r - PW'(q0 * PW'(PCT_SCALE));
  assign qc      = (rem >= PW'(PCT_SCALE)) ? (q0 + PW'(1)) : q0;
  assign idx_nxt = (qc >= PW'(cnt_r)) ? (cnt_r - CW'(1)) : CW'(qc);

  ssq_ram #(.WIDTH(CW + 32), .DEPTH(NUM_INSTANCES)) u_meta_ram (
    .clk     (clk),
    .wr_en   (cmd.finish && !bad_r),
    .wr_addr (inst_a),
    .wr_data ({cnt_r, sum_r}),
    .rd_en   (cmd.meta_rd),
    .rd_addr (inst_a),
    .rd_data (meta_rd_data)
  );

  ssq_ram #(.WIDTH(32), .DEPTH(SD)) u_store_ram (
    .clk     (clk),
    .wr_en   (cmd.ins_wr || cmd.shift_wr),
    .wr_addr (store_wr_addr),
    .wr_data (store_wr_data),
    .rd_en   (cmd.scan_rd || cmd.q_rd),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
      bad_r  <= 32'(in_item.instance_req) >= 32'(NUM_INSTANCES);
      qv_r   <= '0;
      drop_r <= 1'b0;
    end
    if (cmd.meta_rd) begin
      base_r <= SAW'(inst_a) * SAW'(CAPACITY);
    end
    if (cmd.meta_load) begin
      cnt_r <= valid_r[inst_a] ? meta_rd_data[CW+31:32] : '0;
      sum_r <= valid_r[inst_a] ? meta_rd_data[31:0] : '0;
    end
    if (cmd.mark_drop) begin
      drop_r <= 1'b1;
    end
    if (cmd.obs_init) begin
      j_r <= cnt_r;
    end
    if (cmd.shift_wr) begin
      j_r <= j_r - CW'(1);
    end
    if (cmd.ins_wr) begin
      cnt_r <= cnt_r + CW'(1);
      sum_r <= sum_r + item_r.sample_value;
    end
    if (cmd.clear) begin
      cnt_r <= '0;
      sum_r <= '0;
    end
    if (cmd.q_mul) begin
      prod_r <= PW'(cnt_r) * PW'(item_r.quantile_pct);
    end
    if (cmd.q_div) begin
      mul_r <= MW'(prod_r) * MW'(QM);
    end
    if (cmd.q_idx) begin
      idx_r <= idx_nxt;
    end
    if (cmd.q_cap) begin
      qv_r <= store_rd_data;
    end
    if (cmd.finish) begin
      if (bad_r) begin
        out_r <= '0;
      end else begin
        out_r.quantile_value <= qv_r;
        out_r.count_after    <= 9'(cnt_r);
        out_r.sum_after      <= sum_r;
        out_r.dropped        <= drop_r;
      end
    end
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.finish && !bad_r) begin
        valid_r[inst_a] <= 1'b1;
      end
    end
  end

  assign stat.bad_inst = bad_r;
  assign stat.command  = item_r.command;
  assign stat.empty    = (cnt_r == '0);
  assign stat.full     = (32'(cnt_r) >= 32'(CAPACITY));
  assign stat.j_zero   = (j_r == '0);
  assign stat.le       = (item_r.sample_value <= $signed(store_rd_data));

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: hw/rtl/ssq_ctrl.sv
module ssq_ctrl import ssq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ssq_stat_t stat,
  output ssq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_META,
    S_LOAD,
    S_DECIDE,
    S_SCAN,
    S_SCMP,
    S_QMUL,
    S_QDIV,
    S_QIDX,
    S_QRD,
    S_QCAP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_r_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_META;
        end
      end
      S_META: begin
        if (stat.bad_inst) begin
          state_nxt = S_DONE;
        end else begin
          cmd.meta_rd = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.meta_load = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        case (stat.command)
          CMD_OBSERVE: begin
            if (stat.full) begin
              cmd.mark_drop = 1'b1;
            end else begin
              cmd.obs_init = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          CMD_QUERY: begin
            if (!stat.empty) begin
              state_nxt = S_QMUL;
            end
          end
          CMD_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.j_zero) begin
          cmd.ins_wr = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_SCMP;
        end
      end
      S_SCMP: begin
        if (stat.le) begin
          cmd.shift_wr = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          cmd.ins_wr = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_QMUL: begin
        cmd.q_mul = 1'b1;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        cmd.q_div = 1'b1;
        state_nxt = S_QIDX;
      end
      S_QIDX: begin
        cmd.q_idx = 1'b1;
        state_nxt = S_QRD;
      end
      S_QRD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = S_QCAP;
      end
      S_QCAP: begin
        cmd.q_cap = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy_r_nxt = (state_nxt != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_r_nxt;
    end
  end

  assign busy = busy_r;

endmodule

// File: hw/rtl/sorted_summary_quantile.sv
// Sorted summary quantile.
// Keeps NUM_INSTANCES summaries, each a sorted sample buffer of CAPACITY words,
// a count and a wrapping 32-bit sum. An input transaction (in_item) is taken
// on a clock edge with start high and busy low; busy then stays high until the
// work is done. command selects observe (sorted insert), quantile query or
// clear for the instance in instance_req.
// Exactly one result transaction follows each input: out_item is valid for one
// cycle with out_valid high. The receiver cannot stall; results are not held.
// Run time of an observe grows with k, the number of held samples that are not
// below the new one; a full buffer, a clear, an unused code, an empty query, a
// query and an instance out of range each take a path that does not depend on
// the held samples. The longest runs come from the insertion scan: one read and
// one write of the sample memory per shifted entry, on a single read port with
// registered data.
// busy drops in the cycle of the strobe, so the next transaction can be taken
// there. Sync reset (rst_n low) empties every instance; sample memory is not
// cleared, only words below a count are ever read.
`include "sorted_summary_quantile_defines.svh"

module sorted_summary_quantile import ssq_pkg::*; #(
  parameter int unsigned CAPACITY      = 256,
  parameter int unsigned NUM_INSTANCES = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ssq_in_t  in_item,
  output logic     out_valid,
  output ssq_out_t out_item
);

  ssq_cmd_t  cmd;
  ssq_stat_t stat;

  ssq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ssq_dp #(
    .CAPACITY      (CAPACITY),
    .NUM_INSTANCES (NUM_INSTANCES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `SSQ_ASSERT_IMP(a_out_after_busy, out_valid, $past(busy), "result without pending transaction")
  `SSQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `SSQ_ASSERT_IMP(a_drop_zero_q, out_valid && out_item.dropped,
                  out_item.quantile_value == 0, "dropped observe with nonzero quantile")
  `SSQ_ASSERT_IMP(a_count_bound, out_valid,
                  32'(out_item.count_after) <= 32'(CAPACITY), "count above capacity")

endmodule

// File: tb/sorted_summary_quantile_tb.sv
module sorted_summary_quantile_tb;
  import ssq_pkg::*;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned NUM_INST    = 4;
  localparam int          STALL_LIMIT = 4000;
  localparam int          END_SETTLE  = 20;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct {
    ssq_in_t item;
    bit      drain_first;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  ssq_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  ssq_out_t out_item;

  sorted_summary_quantile #(
    .CAPACITY      (CAPACITY),
    .NUM_INSTANCES (NUM_INST)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // Shadow of the summaries.
  logic signed [31:0] held_samples [NUM_INST][CAPACITY];
  int unsigned        held_num     [NUM_INST];
  logic signed [31:0] held_total   [NUM_INST];

  pending_t pending_items[$];
  ssq_out_t expected_summaries[$];

  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int stall_cycles = 0;
  int hold_left    = 0;
  int stretch_left = 0;
  bit idle_on      = 1'b0;
  int queued       = 0;
  int n_observe = 0, n_drop = 0, n_query = 0, n_clear = 0, n_unused = 0;

  function automatic ssq_out_t summarize_item(ssq_in_t it);
    ssq_out_t    r;
    int unsigned inst;
    int unsigned n;
    int unsigned pos;
    int unsigned idx;
    r    = '0;
    inst = 32'(it.instance_req);
    if (inst >= NUM_INST) return r;
    n = held_num[inst];
    case (it.command)
      CMD_OBSERVE: begin
        n_observe++;
        if (n >= CAPACITY) begin
          r.dropped = 1'b1;
          n_drop++;
        end else begin
          pos = n;
          for (int unsigned i = 0; i < n; i++) begin
            if ($signed(it.sample_value) <= $signed(held_samples[inst][i])) begin
              pos = i;
              break;
            end
          end
          for (int unsigned i = n; i > pos; i--) held_samples[inst][i] = held_samples[inst][i-1];
          held_samples[inst][pos] = it.sample_value;
          held_num[inst]   = n + 1;
          held_total[inst] = held_total[inst] + it.sample_value;
        end
      end
      CMD_QUERY: begin
        n_query++;
        if (n != 0) begin
          idx = (n * it.quantile_pct) / PCT_SCALE;
          if (idx >= n) idx = n - 1;
          r.quantile_value = held_samples[inst][idx];
        end
      end
      CMD_CLEAR: begin
        n_clear++;
        held_num[inst]   = 0;
        held_total[inst] = '0;
      end
      default: n_unused++;
    endcase
    r.count_after = held_num[inst][8:0];
    r.sum_after   = held_total[inst];
    return r;
  endfunction

  function automatic int draw_gap();
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(8, 40);
      idle_on      = ($urandom_range(0, 2) != 0);
    end
    stretch_left--;
    return idle_on ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic logic signed [31:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2:    return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] draw_pct();
    return 7'(($urandom_range(0, 7) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100));
  endfunction

  task automatic add_item(logic [1:0] cmd, logic [1:0] inst, logic signed [31:0] value,
                          logic [6:0] pct, bit drain = 1'b0);
    pending_t p;
    p.item.command      = cmd;
    p.item.instance_req = inst;
    p.item.sample_value = value;
    p.item.quantile_pct = pct;
    p.drain_first       = drain;
    pending_items.push_back(p);
    queued++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, want, got);
    end
  endtask

  // Driver
  always @(posedge clk) begin
    logic     go;
    pending_t p;
    if (!rst_n) begin
      start     <= 1'b0;
      hold_left = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_summaries.push_back(summarize_item(in_item));
        items_sent++;
        go        = 1'b0;
        hold_left = draw_gap();
      end
      if (!go) begin
        if (hold_left > 0) begin
          hold_left--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].drain_first ||
                      items_sent == results_seen + int'(out_valid))) begin
          p = pending_items.pop_front();
          in_item <= p.item;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  // Monitor
  always @(posedge clk) begin
    ssq_out_t want;
    if (rst_n && out_valid) begin
      if (expected_summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %0h", out_item);
      end else begin
        want = expected_summaries.pop_front();
        check_field("quantile_value", want.quantile_value, out_item.quantile_value);
        check_field("count_after", 32'(want.count_after), 32'(out_item.count_after));
        check_field("sum_after", want.sum_after, out_item.sum_after);
        check_field("dropped", 32'(want.dropped), 32'(out_item.dropped));
      end
      results_seen <= results_seen + 1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", stall_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [1:0] cmd;
    logic [1:0] fill_inst;
    int         fill_obs;
    int         rand_start;

    foreach (held_num[i]) begin
      held_num[i]   = 0;
      held_total[i] = '0;
    end

    // Directed: empty query, extremes, duplicates, sum wrap, pct over 100, code 3.
    add_item(CMD_QUERY,   2'd0, $urandom, 7'd50);
    add_item(CMD_OBSERVE, 2'd0, 32'sh7fffffff, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd0, 32'sh80000000, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd0, 32'sh0, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd0, -32'sd1, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd0, 32'sd5, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd0, 32'sd5, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd0, 32'sh7fffffff, 7'($urandom));
    add_item(CMD_QUERY,   2'd0, $urandom, 7'd0);
    add_item(CMD_QUERY,   2'd0, $urandom, 7'd50);
    add_item(CMD_QUERY,   2'd0, $urandom, 7'd100);
    add_item(CMD_QUERY,   2'd0, $urandom, 7'd127);
    add_item(CMD_UNUSED,  2'd0, $urandom, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd1, 32'sd1, 7'($urandom));
    add_item(CMD_QUERY,   2'd1, $urandom, 7'd99, 1'b1);
    add_item(CMD_CLEAR,   2'd0, $urandom, 7'($urandom));
    add_item(CMD_QUERY,   2'd0, $urandom, 7'd0);
    add_item(CMD_CLEAR,   2'd2, $urandom, 7'($urandom));
    add_item(CMD_OBSERVE, 2'd3, -32'sd5, 7'($urandom));
    add_item(CMD_QUERY,   2'd3, $urandom, 7'd127);

    // Fill one instance past capacity, queries sprinkled in.
    rand_start = queued;
    fill_inst  = 2'($urandom_range(0, NUM_INST - 1));
    fill_obs   = 0;
    add_item(CMD_CLEAR, fill_inst, $urandom, 7'($urandom));
    while (fill_obs < CAPACITY + 3) begin
      if ($urandom_range(0, 7) == 0) begin
        add_item(CMD_QUERY, fill_inst, $urandom, draw_pct());
      end else begin
        add_item(CMD_OBSERVE, fill_inst, draw_sample(), 7'($urandom));
        fill_obs++;
      end
    end
    add_item(CMD_QUERY, fill_inst, $urandom, 7'd0, 1'b1);
    add_item(CMD_QUERY, fill_inst, $urandom, 7'd100);
    add_item(CMD_QUERY, fill_inst, $urandom, 7'd127);

    // Mixed traffic over all instances.
    while (queued - rand_start < 500) begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  cmd = CMD_OBSERVE;
        [60:84]: cmd = CMD_QUERY;
        [85:91]: cmd = CMD_CLEAR;
        default: cmd = CMD_UNUSED;
      endcase
      add_item(cmd, 2'($urandom_range(0, NUM_INST - 1)), draw_sample(), draw_pct(),
               $urandom_range(0, 49) == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_items.size() != 0 || start);
    do @(negedge clk); while (expected_summaries.size() != 0);
    repeat (END_SETTLE) @(negedge clk);

    if (expected_summaries.size() != 0) mismatches += expected_summaries.size();
    $display("covered %0d transactions: %0d observes (%0d dropped on a full buffer),",
             items_sent, n_observe, n_drop);
    $display("  %0d quantile queries, %0d clears, %0d unused codes; %0d mismatches",
             n_query, n_clear, n_unused, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
